// File: rtl/sem_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies.
package sem_pkg;

  localparam int PixW = 24;
  localparam int DimW = 11;
  localparam logic [DimW-1:0] MaxHeight = 11'd1024;
  localparam logic [DimW-1:0] ResetWidth = 11'd1024;
  localparam logic [DimW-1:0] ResetHeight = 11'd768;
  localparam logic [20:0] ClampLimit = 21'd65280;
  localparam logic [7:0] ClampMax = 8'd255;

  localparam logic CfgWidth = 1'b0;
  localparam logic CfgHeight = 1'b1;

  localparam logic KindPixel = 1'b0;

  // one 3x3 window with border taps already forced to zero
  typedef struct packed {
    logic [8:0][PixW-1:0] pix;
    logic                 last;
  } sem_item_t;

  // absolute Sobel gradient of one channel (byte lane sel), x or y direction
  function automatic logic [9:0] abs_grad(input logic [8:0][PixW-1:0] p,
                                          input logic [1:0] sel,
                                          input logic dir_y);
    logic [7:0] b [9];
    logic [10:0] pos;
    logic [10:0] neg;
    for (int i = 0; i < 9; i++) begin
      b[i] = p[i][8*(2-sel) +: 8];
    end
    if (dir_y) begin
      pos = 11'(b[6]) + {2'b0, b[7], 1'b0} + 11'(b[8]);
      neg = 11'(b[0]) + {2'b0, b[1], 1'b0} + 11'(b[2]);
    end else begin
      pos = 11'(b[2]) + {2'b0, b[5], 1'b0} + 11'(b[8]);
      neg = 11'(b[0]) + {2'b0, b[3], 1'b0} + 11'(b[6]);
    end
    abs_grad = (pos >= neg) ? 10'(pos - neg) : 10'(neg - pos);
  endfunction

endpackage

// File: rtl/sem_if.sv
`timescale 1ns / 1ps
// Stream and configuration channel interfaces.
// No dependencies.
interface sem_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, kind, in_red, in_green, in_blue, input ready);
  modport sink (input valid, kind, in_red, in_green, in_blue, output ready);
endinterface

interface sem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_red;
  logic [7:0] edge_green;
  logic [7:0] edge_blue;
  logic       frame_end;
  modport source (output valid, edge_red, edge_green, edge_blue, frame_end, input ready);
  modport sink (input valid, edge_red, edge_green, edge_blue, frame_end, output ready);
endinterface

interface sem_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/sobel_edge_magnitude_rgb_core.sv
`timescale 1ns / 1ps
// Sobel edge magnitude core for RGB pixel streams.
// Front end does a line store read, then a window update, before it takes the next item.
// Back end handles one result at a time: gradients, squares, 8 root steps, output.
// A two-entry window queue decouples them.
// Synchronous reset clears counters, window and handshakes; line stores are not cleared.
module sobel_edge_magnitude_rgb_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic      clk,
  input  logic      rst,
  sem_in_if.sink    pixel_in,
  sem_cfg_if.sink   cfg,
  sem_out_if.source edge_out
);
  import sem_pkg::*;

  logic      q_full;
  logic      push;
  sem_item_t push_item;
  logic      pop;
  logic      nonempty;
  sem_item_t head;

  sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk(clk), .rst(rst), .pixel_in(pixel_in), .cfg(cfg),
    .q_full(q_full), .push(push), .push_item(push_item)
  );

  sem_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item), .full(q_full),
    .pop(pop), .nonempty(nonempty), .head(head)
  );

  sem_back u_back (
    .clk(clk), .rst(rst), .nonempty(nonempty), .head(head), .pop(pop),
    .edge_out(edge_out)
  );

endmodule

// File: rtl/sem_front.sv
`timescale 1ns / 1ps
// Front end: configuration, position counters, line stores and 3x3 window.
// Depends on sem_pkg and sem_if.
module sem_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  sem_in_if.sink             pixel_in,
  sem_cfg_if.sink            cfg,
  input  logic               q_full,
  output logic               push,
  output sem_pkg::sem_item_t push_item
);
  import sem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = WW + DimW;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_WORK = 1'b1;

  logic [DimW-1:0] frame_width;
  logic [DimW-1:0] frame_height;
  logic [WW-1:0]   w;
  logic [DimW-1:0] h;
  logic [PW-1:0]   area;

  logic            state;
  logic [CW-1:0]   col;
  logic [DimW-1:0] row;
  logic [PW-1:0]   pos;
  logic [PixW-1:0] v;
  logic [PixW-1:0] rd_upper;
  logic [PixW-1:0] rd_lower;
  logic [8:0][PixW-1:0] window;
  logic [8:0][PixW-1:0] window_next;

  logic [PixW-1:0] mem_upper [MAX_WIDTH];
  logic [PixW-1:0] mem_lower [MAX_WIDTH];

  logic            accept;
  logic            emit;
  logic            last;
  logic [DimW-1:0] cr;
  logic [CW-1:0]   cc;
  logic [2:0]      rok;
  logic [2:0]      cok;

  assign cfg.ready = 1'b1;
  assign pixel_in.ready = (state == F_IDLE) && !q_full;
  assign accept = pixel_in.valid && pixel_in.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= ResetWidth;
      frame_height <= ResetHeight;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CfgWidth:  frame_width <= cfg.data;
        CfgHeight: frame_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (frame_width == '0) w = WW'(1);
    else if (32'(frame_width) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(frame_width);
    if (frame_height == '0) h = DimW'(1);
    else if (frame_height > MaxHeight) h = MaxHeight;
    else h = frame_height;
  end

  always_ff @(posedge clk) begin
    area <= PW'(w) * PW'(h);
  end

  // line store reads
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_upper <= mem_upper[col];
      rd_lower <= mem_lower[col];
      if (pixel_in.kind == KindPixel && row < h && 32'(col) < 32'(w))
        v <= {pixel_in.in_red, pixel_in.in_green, pixel_in.in_blue};
      else
        v <= '0;
    end
  end

  // line store writes
  always_ff @(posedge clk) begin
    if (state == F_WORK) begin
      mem_upper[col] <= rd_lower;
      mem_lower[col] <= v;
    end
  end

  // window shift, border mask and emit decision
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      window_next[3*r] = window[3*r+1];
      window_next[3*r+1] = window[3*r+2];
    end
    window_next[2] = rd_upper;
    window_next[5] = rd_lower;
    window_next[8] = v;

    emit = (row >= DimW'(2)) || (row == DimW'(1) && col != '0);
    cr = (col == '0) ? row - DimW'(2) : row - DimW'(1);
    cc = (col == '0) ? CW'(w - WW'(1)) : col - CW'(1);
    rok[0] = cr != '0;
    rok[1] = 1'b1;
    rok[2] = 32'(cr) + 1 < 32'(h);
    cok[0] = cc != '0;
    cok[1] = 1'b1;
    cok[2] = 32'(cc) + 1 < 32'(w);
    last = emit && (32'(pos) + 1 >= 32'(area));

    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        push_item.pix[3*r+c] = (rok[r] && cok[c]) ? window_next[3*r+c] : '0;
      end
    end
    push_item.last = last;
    push = (state == F_WORK) && emit;
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      col <= '0;
      row <= '0;
      pos <= '0;
      window <= '0;
    end else begin
      unique case (state)
        F_IDLE: if (accept) state <= F_WORK;
        F_WORK: begin
          state <= F_IDLE;
          window <= window_next;
          if (emit) pos <= pos + PW'(1);
          if (32'(col) + 1 >= 32'(w)) begin
            col <= '0;
            row <= row + DimW'(1);
          end else begin
            col <= col + CW'(1);
          end
          if (last) begin
            col <= '0;
            row <= '0;
            pos <= '0;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/sem_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of windows between front and back end.
// Depends on sem_pkg.
module sem_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sem_pkg::sem_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               nonempty,
  output sem_pkg::sem_item_t head
);
  import sem_pkg::*;

  sem_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign nonempty = count != 2'd0;
  assign head = slots[rd_ptr];

  // store entries
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/sem_back.sv
`timescale 1ns / 1ps
// Back end: Sobel gradients, squared magnitude, bit-serial rounded root.
// Depends on sem_pkg and sem_if.
module sem_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               nonempty,
  input  sem_pkg::sem_item_t head,
  output logic               pop,
  sem_out_if.source          edge_out
);
  import sem_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SQ   = 2'd1;
  localparam logic [1:0] B_ROOT = 2'd2;
  localparam logic [1:0] B_DONE = 2'd3;

  logic [1:0]  state;
  logic [2:0]  k;
  logic        last;
  logic [9:0]  gx [3];
  logic [9:0]  gy [3];
  logic [20:0] s [3];
  logic [7:0]  n [3];
  logic [7:0]  m [3];
  logic [7:0]  res [3];
  logic        out_free;

  assign pop = (state == B_IDLE) && nonempty;
  assign out_free = !edge_out.valid || edge_out.ready;

  // trial bit and final rounding per channel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m[i] = n[i] | (8'd1 << k);
      if (s[i] > ClampLimit) res[i] = ClampMax;
      else if (s[i] > 21'(n[i]) * 21'(n[i]) + 21'(n[i])) res[i] = n[i] + 8'd1;
      else res[i] = n[i];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (pop) begin
          last <= head.last;
          for (int i = 0; i < 3; i++) begin
            gx[i] <= abs_grad(head.pix, 2'(i), 1'b0);
            gy[i] <= abs_grad(head.pix, 2'(i), 1'b1);
          end
        end
      end
      B_SQ: begin
        for (int i = 0; i < 3; i++) begin
          s[i] <= 21'(gx[i]) * 21'(gx[i]) + 21'(gy[i]) * 21'(gy[i]);
          n[i] <= '0;
        end
      end
      B_ROOT: begin
        for (int i = 0; i < 3; i++) begin
          if (21'(m[i]) * 21'(m[i]) <= s[i]) n[i] <= m[i];
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      k <= '0;
    end else begin
      unique case (state)
        B_IDLE: if (pop) state <= B_SQ;
        B_SQ: begin
          k <= 3'd7;
          state <= B_ROOT;
        end
        B_ROOT: begin
          k <= k - 3'd1;
          if (k == 3'd0) state <= B_DONE;
        end
        B_DONE: if (out_free) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_out.valid <= 1'b0;
    end else if (state == B_DONE && out_free) begin
      edge_out.valid <= 1'b1;
    end else if (edge_out.ready) begin
      edge_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_DONE && out_free) begin
      edge_out.edge_red <= res[0];
      edge_out.edge_green <= res[1];
      edge_out.edge_blue <= res[2];
      edge_out.frame_end <= last;
    end
  end

endmodule

// File: dv/sem_tb_if.sv
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces come from rtl/sem_if.sv.
// This file holds the pixel/result beat types shared by the testbench.
// No dependencies.
package sem_tb_types;
  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } edge_beat_t;
endpackage

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for sobel_edge_magnitude_rgb_core: random frames of
// varied size through a bursty driver and a stalling receiver, checked against
// an in-bench Sobel magnitude predictor. Depends on sem_pkg, sem_if, sem_tb_types.
module testbench;
  import sem_pkg::*;
  import sem_tb_types::*;

  localparam int MaxW = 1024;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sem_in_if  pixel_in ();
  sem_cfg_if cfg ();
  sem_out_if edge_out ();

  sobel_edge_magnitude_rgb_core #(.MAX_WIDTH(MaxW)) DUT (
    .clk(clk), .rst(rst), .pixel_in(pixel_in), .cfg(cfg), .edge_out(edge_out)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [23:0] upper_line [MaxW];
  logic [23:0] lower_line [MaxW];
  logic [23:0] win [3][3];
  int unsigned col_cnt, row_cnt, out_pos;
  logic [10:0] width_reg, height_reg;

  pixel_beat_t pending_pixels[$];
  edge_beat_t  expected_edges[$];
  int          err_cnt = 0;
  int unsigned sent_cnt = 0;
  bit          beat_taken = 1'b0;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MaxW) w = MaxW;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > MaxHeight) h = MaxHeight;
    return h;
  endfunction

  function automatic logic [7:0] rounded_root(int unsigned s);
    int unsigned n, m;
    n = 0;
    if (s > 65280) return 8'd255;
    for (int b = 128; b != 0; b >>= 1) begin
      m = n | b;
      if (m * m <= s) n = m;
    end
    if (s > n * n + n) n++;
    return n[7:0];
  endfunction

  function automatic logic [7:0] lane_magnitude(bit ok [3][3], int sh);
    int p [3][3];
    int gx, gy;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        p[r][c] = ok[r][c] ? int'((win[r][c] >> sh) & 24'hFF) : 0;
    gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
    gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
    return rounded_root(gx * gx + gy * gy);
  endfunction

  // advance the predictor by one accepted beat
  task automatic predict_edge(pixel_beat_t pb);
    int unsigned w, h, x, cr, cc;
    logic [23:0] v;
    bit emit, last;
    bit rok [3], cok [3], ok [3][3];
    edge_beat_t eb;
    w = eff_width();
    h = eff_height();
    x = col_cnt < MaxW ? col_cnt : MaxW - 1;
    v = '0;
    last = 0;
    if (pb.kind == KindPixel && row_cnt < h && col_cnt < w) v = {pb.red, pb.green, pb.blue};
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = upper_line[x];
    win[1][2] = lower_line[x];
    win[2][2] = v;
    upper_line[x] = lower_line[x];
    lower_line[x] = v;
    emit = row_cnt >= 2 || (row_cnt == 1 && col_cnt >= 1);
    if (emit) begin
      cr = (col_cnt == 0) ? row_cnt - 2 : row_cnt - 1;
      cc = (col_cnt == 0) ? w - 1 : col_cnt - 1;
      rok[0] = cr != 0; rok[1] = 1; rok[2] = cr + 1 < h;
      cok[0] = cc != 0; cok[1] = 1; cok[2] = cc + 1 < w;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          ok[r][c] = rok[r] && cok[c];
      last = out_pos + 1 >= w * h;
      eb.red = lane_magnitude(ok, 16);
      eb.green = lane_magnitude(ok, 8);
      eb.blue = lane_magnitude(ok, 0);
      eb.frame_end = last;
      expected_edges.push_back(eb);
      out_pos++;
    end
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1) & 11'h7FF;
    end else begin
      col_cnt = col_cnt + 1;
    end
    if (last) begin
      col_cnt = 0;
      row_cnt = 0;
      out_pos = 0;
    end
  endtask

  // driver: bursts of beats with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      pixel_in.valid <= 1'b0;
    end else if (pixel_in.valid && !beat_taken) begin
      // hold the beat until taken
    end else begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        pixel_in.valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        pixel_in.valid <= 1'b1;
        {pixel_in.kind, pixel_in.in_red, pixel_in.in_green, pixel_in.in_blue}
          <= pending_pixels[0];
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(40, 0);
          gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end
      end else begin
        pixel_in.valid <= 1'b0;
      end
    end
  end

  // record accepted beats and drop them from the pending queue
  always @(posedge clk) begin
    if (!rst && pixel_in.valid && pixel_in.ready) begin
      predict_edge({pixel_in.kind, pixel_in.in_red, pixel_in.in_green, pixel_in.in_blue});
      void'(pending_pixels.pop_front());
      beat_taken = 1'b1;
      sent_cnt++;
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase++;
    if (rst) edge_out.ready <= 1'b0;
    else if ((stall_phase / 200) % 3 == 0) edge_out.ready <= 1'b1;
    else edge_out.ready <= ($urandom_range(3, 0) != 0);
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    edge_beat_t got, exp_b;
    if (!rst && edge_out.valid && edge_out.ready) begin
      got = {edge_out.edge_red, edge_out.edge_green, edge_out.edge_blue, edge_out.frame_end};
      if (expected_edges.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        err_cnt++;
      end else begin
        exp_b = expected_edges.pop_front();
        if (got.red !== exp_b.red)
          $display("%0t: edge_red expected %0d actual %0d", $time, exp_b.red, got.red);
        if (got.green !== exp_b.green)
          $display("%0t: edge_green expected %0d actual %0d", $time, exp_b.green, got.green);
        if (got.blue !== exp_b.blue)
          $display("%0t: edge_blue expected %0d actual %0d", $time, exp_b.blue, got.blue);
        if (got.frame_end !== exp_b.frame_end)
          $display("%0t: frame_end expected %0d actual %0d", $time, exp_b.frame_end,
                   got.frame_end);
        if (got !== exp_b) err_cnt++;
      end
    end
  end

  // write one register through the config channel
  task automatic write_reg(logic idx, logic [10:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    if (idx == CfgWidth) width_reg = val;
    else height_reg = val;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((pending_pixels.size() > 0 || expected_edges.size() > 0) && guard < 400000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  function automatic pixel_beat_t rand_pixel(int mode);
    pixel_beat_t pb;
    pb.kind = KindPixel;
    case (mode)
      0: begin
        pb.red = 8'hFF; pb.green = 8'h00; pb.blue = 8'hFF;
      end
      1: begin
        pb.red = 8'h00; pb.green = 8'hFF; pb.blue = 8'h00;
      end
      default: begin
        pb.red = 8'($urandom); pb.green = 8'($urandom); pb.blue = 8'($urandom);
      end
    endcase
    return pb;
  endfunction

  // queue one frame: pixels, then width+1 flush beats; noisy frames break the rules
  task automatic queue_frame(int unsigned w, int unsigned h, int mode, bit noisy);
    pixel_beat_t pb;
    int unsigned ew, eh;
    ew = (w == 0) ? 1 : (w > MaxW ? MaxW : w);
    eh = (h == 0) ? 1 : (h > MaxHeight ? MaxHeight : h);
    for (int unsigned i = 0; i < ew * eh; i++) begin
      pb = rand_pixel(mode == 3 ? (((i / ew) + (i % ew)) % 2) : mode);
      if (noisy && $urandom_range(9, 0) == 0) pb.kind = ~KindPixel;
      pending_pixels.push_back(pb);
    end
    for (int unsigned i = 0; i < ew + 1; i++) begin
      pb = rand_pixel(2);
      pb.kind = (noisy && $urandom_range(1, 0)) ? KindPixel : ~KindPixel;
      pending_pixels.push_back(pb);
    end
  endtask

  task automatic run_frame(logic [10:0] w, logic [10:0] h, int mode, bit noisy);
    write_reg(CfgWidth, w);
    write_reg(CfgHeight, h);
    queue_frame(w, h, mode, noisy);
    wait_drained();
  endtask

  initial begin
    int unsigned w, h;
    pixel_in.valid = 1'b0;
    pixel_in.kind = 1'b0;
    pixel_in.in_red = '0;
    pixel_in.in_green = '0;
    pixel_in.in_blue = '0;
    cfg.valid = 1'b0;
    cfg.index = 1'b0;
    cfg.data = '0;
    edge_out.ready = 1'b0;
    width_reg = ResetWidth;
    height_reg = ResetHeight;
    for (int i = 0; i < MaxW; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        win[r][c] = '0;
    col_cnt = 0; row_cnt = 0; out_pos = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, single pixel, out-of-range registers
    run_frame(11'd1, 11'd1, 0, 0);
    run_frame(11'd0, 11'd0, 1, 0);
    run_frame(11'd3, 11'd3, 3, 0);
    run_frame(11'd4, 11'd2, 0, 1);
    run_frame(11'd1, 11'd5, 2, 0);
    run_frame(11'd40, 11'd2, 3, 0);
    run_frame(11'd1, 11'd2047, 2, 0);

    // random frames, mostly small
    while (sent_cnt < 1700) begin
      w = $urandom_range(12, 1);
      h = $urandom_range(10, 1);
      if ($urandom_range(15, 0) == 0) w = $urandom_range(64, 13);
      if ($urandom_range(15, 0) == 0) h = $urandom_range(1, 0);
      if (w * h > 300) h = 1;
      run_frame(11'(w), 11'(h), $urandom_range(3, 0) == 0 ? $urandom_range(3, 0) : 2,
                $urandom_range(7, 0) == 0);
    end
    if (err_cnt == 0 && expected_edges.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

// File: filelist.f
rtl/sem_pkg.sv
rtl/sem_if.sv
rtl/sem_front.sv
rtl/sem_queue.sv
rtl/sem_back.sv
rtl/sobel_edge_magnitude_rgb_core.sv
dv/sem_tb_if.sv
dv/testbench.sv
